// ===== hw/rtl/bba_pkg.sv =====
// Shared types and codes for the bitmap block allocator.
`timescale 1ns / 1ps
package bba_pkg;

	localparam int BLOCK_W = 16;
	localparam int COUNT_W = 17;

	localparam logic [1:0] REQ_ALLOC  = 2'd0;
	localparam logic [1:0] REQ_FREE   = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;
	localparam logic [1:0] REQ_FORMAT = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	localparam logic REG_TOTAL    = 1'b0;
	localparam logic REG_RESERVED = 1'b1;

	localparam logic [COUNT_W-1:0] TOTAL_RESET    = 17'h10000;
	localparam logic [COUNT_W-1:0] RESERVED_RESET = 17'h00000;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [BLOCK_W-1:0] block_number;
	} bba_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [BLOCK_W-1:0] result_block;
		logic               bit_value;
		logic [COUNT_W-1:0] free_count;
	} bba_rsp_t;

	typedef struct packed {
		logic       accept;
		logic       div;
		logic       fetch;
		logic       scan;
		logic       sweep;
		logic       clear;
		logic       alloc_wr;
		logic       free_wr;
		logic       fin;
		logic [1:0] fin_status;
	} bba_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       count_zero;
		logic       out_of_range;
		logic       word_open;
		logic       scan_dry;
		logic       hit_in_range;
		logic       sweep_last;
	} bba_stat_t;

endpackage

// ===== hw/rtl/bitmap_block_allocator_core.sv =====
// Top level: configuration registers, sequencer and map datapath.
`timescale 1ns / 1ps
// First-fit bitmap block allocator. A request is taken when start is high and busy
// is low; its result appears on rsp for exactly one cycle with done high, and must be
// captured then, since the block cannot be held off. All timing is set by the single
// read port of the usage map memory, which holds one map word of WORD_BITS blocks per
// entry. Free and read requests pass through decode, fetch and modify states; an
// out-of-range number or an allocate with a zero count finishes in decode. An allocate
// reads words in order up to the first word with a clear bit (at most
// MAX_BLOCKS/WORD_BITS words), then sets that bit if it lies in range. A format sweeps
// every map word. After reset the block stays busy while it clears the map;
// configuration writes are taken during that time.
module bitmap_block_allocator_core import bba_pkg::*; #(
	parameter int MAX_BLOCKS = 65536,
	parameter int WORD_BITS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  bba_req_t    req,
	output logic        done,
	output bba_rsp_t    rsp
);

	logic [COUNT_W-1:0] total_q;
	logic [COUNT_W-1:0] reserved_q;
	logic               reg_sel;
	logic               wr_en;
	bba_cmd_t           cmd;
	bba_stat_t          stat;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel & penable & pwrite;
	assign prdata  = (reg_sel == REG_RESERVED) ? 32'(reserved_q) : 32'(total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= TOTAL_RESET;
			reserved_q <= RESERVED_RESET;
		end else if (wr_en) begin
			if (reg_sel == REG_TOTAL) begin
				total_q <= pwdata[COUNT_W-1:0];
			end else begin
				reserved_q <= pwdata[COUNT_W-1:0];
			end
		end
	end

	bba_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.cmd   (cmd)
	);

	bba_dp #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.total_blocks   (total_q),
		.reserved_blocks(reserved_q),
		.req            (req),
		.cmd            (cmd),
		.stat           (stat),
		.done           (done),
		.rsp            (rsp)
	);

endmodule

// ===== hw/rtl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
// Request sequencer for the bitmap block allocator.
`timescale 1ns / 1ps
module bba_ctrl import bba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  bba_stat_t stat,
	output bba_cmd_t  cmd
);

	localparam logic [2:0] S_CLR    = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DECODE = 3'd2;
	localparam logic [2:0] S_FETCH  = 3'd3;
	localparam logic [2:0] S_MODIFY = 3'd4;
	localparam logic [2:0] S_SCAN   = 3'd5;
	localparam logic [2:0] S_HIT    = 3'd6;
	localparam logic [2:0] S_FMT    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.sweep = 1'b1;
				cmd.clear = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.div = 1'b1;
				unique case (stat.req_type)
					REQ_ALLOC: begin
						if (stat.count_zero) begin
							cmd.fin = 1'b1;
							cmd.fin_status = ST_NOFREE;
							state_d = S_IDLE;
						end else begin
							state_d = S_SCAN;
						end
					end
					REQ_FREE, REQ_READ: begin
						if (stat.out_of_range) begin
							cmd.fin = 1'b1;
							cmd.fin_status = ST_RANGE;
							state_d = S_IDLE;
						end else begin
							state_d = S_FETCH;
						end
					end
					REQ_FORMAT: begin
						state_d = S_FMT;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = S_MODIFY;
			end
			S_MODIFY: begin
				cmd.free_wr = (stat.req_type == REQ_FREE);
				cmd.fin = 1'b1;
				cmd.fin_status = ST_OK;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				priority if (stat.word_open) begin
					state_d = S_HIT;
				end else if (stat.scan_dry) begin
					cmd.fin = 1'b1;
					cmd.fin_status = ST_NOFREE;
					state_d = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_HIT: begin
				cmd.fin = 1'b1;
				if (stat.hit_in_range) begin
					cmd.alloc_wr = 1'b1;
					cmd.fin_status = ST_OK;
				end else begin
					cmd.fin_status = ST_NOFREE;
				end
				state_d = S_IDLE;
			end
			S_FMT: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					cmd.fin = 1'b1;
					cmd.fin_status = ST_OK;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/bba_dp.sv =====
// Datapath: usage map memory, word scan, bit update and free-block count.
`timescale 1ns / 1ps
module bba_dp import bba_pkg::*; #(
	parameter int MAX_BLOCKS = 65536,
	parameter int WORD_BITS  = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COUNT_W-1:0] total_blocks,
	input  logic [COUNT_W-1:0] reserved_blocks,
	input  bba_req_t           req,
	input  bba_cmd_t           cmd,
	output bba_stat_t          stat,
	output logic               done,
	output bba_rsp_t           rsp
);

	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int CW        = $clog2(MAX_BLOCKS + 1);
	localparam int BASE_W    = $clog2(MAX_BLOCKS + 2 * WORD_BITS);
	// block number / WORD_BITS as a multiply by a rounded-up reciprocal
	localparam int DIV_SH    = BLOCK_W + BIT_W;
	localparam int DIV_M     = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int DM_W      = BLOCK_W + 2;
	localparam int PROD_W    = BLOCK_W + DM_W;

	logic [1:0]           req_q;
	logic [BLOCK_W-1:0]   bn_q;
	logic [AW-1:0]        q_q;
	logic [BIT_W-1:0]     rem_q;
	logic [AW-1:0]        scan_addr_q;
	logic [BASE_W-1:0]    scan_base_q;
	logic                 rd_vld_s1;
	logic [AW-1:0]        data_addr_s1;
	logic [BASE_W-1:0]    data_base_s1;
	logic [AW-1:0]        hit_addr_q;
	logic [BIT_W-1:0]     hit_bit_q;
	logic [WORD_BITS-1:0] hit_word_q;
	logic [BASE_W-1:0]    hit_n_q;
	logic [CW-1:0]        free_q;
	logic [CW-1:0]        free_d;
	logic                 done_q;
	bba_rsp_t             rsp_q;

	logic [CW-1:0]        eff_tot;
	logic [CW-1:0]        eff_res;
	logic [BASE_W-1:0]    tot_b;
	logic [BASE_W-1:0]    res_b;
	logic                 issue_ok;
	logic [PROD_W-1:0]    prod;
	logic [31:0]          qmul;
	logic [BIT_W-1:0]     ffz;
	logic [BIT_W-1:0]     part_k;
	logic [WORD_BITS-1:0] fmt_word;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] wdata;
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;
	logic                 we;

	assign eff_tot = (32'(total_blocks) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(total_blocks);
	assign eff_res = (32'(reserved_blocks) > 32'(eff_tot)) ? eff_tot : CW'(reserved_blocks);
	assign tot_b   = BASE_W'(eff_tot);
	assign res_b   = cmd.clear ? '0 : BASE_W'(eff_res);
	assign issue_ok = (scan_base_q < tot_b);

	assign prod = PROD_W'(bn_q) * PROD_W'(DIV_M);
	assign qmul = 32'(q_q) * 32'(WORD_BITS);

	always_comb begin
		ffz = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!rdata[i]) begin
				ffz = BIT_W'(i);
			end
		end
	end

	// format pattern: leading reserved blocks set, rest clear
	always_comb begin
		part_k = BIT_W'(res_b - scan_base_q);
		fmt_word = '0;
		if ((scan_base_q + BASE_W'(WORD_BITS)) <= res_b) begin
			fmt_word = '1;
		end else if (scan_base_q < res_b) begin
			for (int i = 0; i < WORD_BITS; i++) begin
				fmt_word[i] = (BIT_W'(i) < part_k);
			end
		end
	end

	always_comb begin
		we = cmd.sweep | cmd.alloc_wr | cmd.free_wr;
		waddr = scan_addr_q;
		wdata = fmt_word;
		if (cmd.alloc_wr) begin
			waddr = hit_addr_q;
			wdata = hit_word_q | (WORD_BITS'(1) << hit_bit_q);
		end else if (cmd.free_wr) begin
			waddr = q_q;
			wdata = rdata & ~(WORD_BITS'(1) << rem_q);
		end
		raddr = cmd.fetch ? q_q : scan_addr_q;
	end

	bba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		free_d = free_q;
		if (cmd.alloc_wr) begin
			free_d = free_q - CW'(1);
		end else if (cmd.free_wr && (free_q < eff_tot)) begin
			free_d = free_q + CW'(1);
		end else if (cmd.sweep && cmd.fin) begin
			free_d = eff_tot - eff_res;
		end
	end

	assign stat.req_type     = req_q;
	assign stat.count_zero   = (free_q == '0);
	assign stat.out_of_range = (32'(bn_q) >= 32'(eff_tot));
	assign stat.word_open    = rd_vld_s1 && !(&rdata);
	assign stat.scan_dry     = !rd_vld_s1 && !issue_ok;
	assign stat.hit_in_range = (hit_n_q < tot_b);
	assign stat.sweep_last   = (scan_addr_q == AW'(MAP_WORDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			scan_base_q <= '0;
			rd_vld_s1   <= 1'b0;
			free_q      <= CW'(MAX_BLOCKS);
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			free_q <= free_d;
			if (cmd.accept) begin
				scan_addr_q <= '0;
				scan_base_q <= '0;
				rd_vld_s1   <= 1'b0;
			end else if (cmd.scan) begin
				rd_vld_s1 <= issue_ok;
				if (issue_ok) begin
					scan_addr_q <= scan_addr_q + AW'(1);
					scan_base_q <= scan_base_q + BASE_W'(WORD_BITS);
				end
			end else if (cmd.sweep) begin
				scan_addr_q <= scan_addr_q + AW'(1);
				scan_base_q <= scan_base_q + BASE_W'(WORD_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req.req_type;
			bn_q  <= req.block_number;
		end
		if (cmd.div) begin
			q_q <= AW'(prod >> DIV_SH);
		end
		if (cmd.fetch) begin
			rem_q <= BIT_W'(bn_q - qmul[BLOCK_W-1:0]);
		end
		if (cmd.scan) begin
			data_addr_s1 <= scan_addr_q;
			data_base_s1 <= scan_base_q;
			if (rd_vld_s1) begin
				hit_addr_q <= data_addr_s1;
				hit_bit_q  <= ffz;
				hit_word_q <= rdata;
				hit_n_q    <= data_base_s1 + BASE_W'(ffz);
			end
		end
		if (cmd.fin) begin
			rsp_q.status     <= cmd.fin_status;
			rsp_q.free_count <= COUNT_W'(free_d);
			rsp_q.bit_value  <= (req_q == REQ_READ) && (cmd.fin_status == ST_OK)
				&& rdata[rem_q];
			unique case (req_q)
				REQ_ALLOC: begin
					rsp_q.result_block <= (cmd.fin_status == ST_OK) ? BLOCK_W'(hit_n_q) : '0;
				end
				REQ_FREE, REQ_READ: begin
					rsp_q.result_block <= bn_q;
				end
				default: begin
					rsp_q.result_block <= '0;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
